>>> rtl/itb_pkg.sv
// Shared types and constants for the interpolated timebase.
`default_nettype none
package itb_pkg;

  localparam int TimeBits  = 48;
  localparam int StepBits  = 40;
  localparam int CountBits = 10;
  localparam int AccBits   = 64;
  localparam int ProdBits  = StepBits + CountBits;
  localparam int IdxBits   = 3;

  localparam logic [IdxBits-1:0] CFG_TICKS_PER_CORR = 3'd0;
  localparam logic [IdxBits-1:0] CFG_NOMINAL_STEP   = 3'd1;
  localparam logic [IdxBits-1:0] CFG_WINDOW_LOW     = 3'd2;
  localparam logic [IdxBits-1:0] CFG_WINDOW_HIGH    = 3'd3;
  localparam logic [IdxBits-1:0] CFG_START_TIME     = 3'd4;

  localparam logic [CountBits-1:0] RST_TICKS_PER_CORR = 10'd100;
  localparam logic [StepBits-1:0]  RST_NOMINAL_STEP   = 40'd655360000;
  localparam logic [StepBits-1:0]  RST_WINDOW_LOW     = 40'd950000;
  localparam logic [StepBits-1:0]  RST_WINDOW_HIGH    = 40'd1050000;
  localparam logic [StepBits-1:0]  STEP_MAX           = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_CAND = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

endpackage
`default_nettype wire

>>> rtl/interpolated_timebase.sv
// Interpolated timebase top level with serial step divider and sequencer.
//
//   Channel   Signals                                 Direction
//   input     in_valid_i, in_ready_o, fine_sample_i   in
//   output    out_valid_o, out_ready_i, current_time_o, tick_kind_o   out
//   config    cfg_we_i, cfg_idx_i, cfg_data_i         in
//
// An interpolated tick passes from acceptance through S_PREP, S_MUL, S_CAND and S_FIN to a valid result.
// A rejected correction passes through S_PREP, S_CAND and S_FIN; an accepted one also runs S_DIV,
// the restoring divider that retires one quotient bit per cycle.
// Reset clears the sequencer, phase, kept time and the first-tick flag.
// The next item is taken while a result waits; its own result waits for the output.
`default_nettype none
module interpolated_timebase import itb_pkg::*; #(
  parameter int SAMPLE_BITS   = 48,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TimeBits-1:0]  fine_sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [TimeBits-1:0]       current_time_o,
  output logic [1:0]                tick_kind_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [IdxBits-1:0]   cfg_idx_i,
  input  wire logic [TimeBits-1:0]  cfg_data_i
);

  localparam int DivBits = StepBits + FRACTION_BITS;
  localparam int CntBits = $clog2(DivBits + 1);
  localparam logic [63:0] SampleMask64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SAMPLE_BITS);
  localparam logic [TimeBits-1:0] SampleMask = SampleMask64[TimeBits-1:0];
  localparam logic [AccBits-1:0] FracMask = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam logic [AccBits-1:0] WholeMax = 64'hFFFF_FFFF_FFFF_FFFF >> FRACTION_BITS;
  localparam logic [DivBits-1:0] StepMaxW = DivBits'(STEP_MAX);
  localparam logic [CntBits-1:0] LastCnt = CntBits'(DivBits - 1);

  state_e                state_q, state_d;
  logic [CountBits-1:0]  tpc_q, tpc_d;
  logic [StepBits-1:0]   nom_q, nom_d;
  logic [StepBits-1:0]   wlo_q, wlo_d;
  logic [StepBits-1:0]   whi_q, whi_d;
  logic [TimeBits-1:0]   start_q, start_d;
  logic                  started_q, started_d;
  logic [TimeBits-1:0]   last_q, last_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic [CountBits-1:0]  phase_q, phase_d;
  logic [AccBits-1:0]    accum_q, accum_d;
  logic [TimeBits-1:0]   sample_q, sample_d;
  logic [CountBits-1:0]  n_q, n_d;
  logic [CountBits-1:0]  ph_q, ph_d;
  logic                  neg_q, neg_d;
  logic [TimeBits-1:0]   mag_q, mag_d;
  logic [ProdBits-1:0]   prod_q, prod_d;
  logic [DivBits-1:0]    quo_q, quo_d;
  logic [CountBits-1:0]  rem_q, rem_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [AccBits-1:0]    cand_q, cand_d;
  kind_e                 kind_q, kind_d;
  logic                  out_valid_q, out_valid_d;
  logic [TimeBits-1:0]   out_time_q, out_time_d;
  logic [1:0]            out_kind_q, out_kind_d;

  logic [TimeBits-1:0]   start_m;
  logic [CountBits-1:0]  n_eff, ph_eff;
  logic [TimeBits-1:0]   base, elapsed;
  logic                  win_ok;
  logic [CountBits:0]    trial, ph_next;
  logic                  trial_ge;
  logic [AccBits-1:0]    add_whole, mag64, frac, whole, acc_new;
  logic                  cand_zero;

  assign start_m = start_q & SampleMask;
  assign n_eff   = (tpc_q == '0) ? CountBits'(1) : tpc_q;
  assign ph_eff  = (phase_q >= n_eff) ? '0 : phase_q;
  assign base    = (ph_eff == '0) ? sample_q : last_q;
  assign elapsed = sample_q - last_q;
  assign win_ok  = (sample_q >= last_q) && (elapsed >= {8'd0, wlo_q})
                   && (elapsed <= {8'd0, whi_q});

  assign trial    = {rem_q, quo_q[DivBits-1]};
  assign trial_ge = trial >= {1'b0, n_q};
  assign ph_next  = {1'b0, ph_q} + (CountBits+1)'(1);

  assign add_whole = AccBits'(prod_q) >> FRACTION_BITS;
  assign mag64     = AccBits'(mag_q);
  assign frac      = AccBits'(prod_q) & FracMask;
  assign acc_new   = (cand_q > accum_q) ? cand_q : accum_q;

  always_comb begin
    cand_zero = 1'b0;
    whole     = '0;
    if (!neg_q) begin
      whole = mag64 + add_whole;
    end else if (add_whole < mag64) begin
      cand_zero = 1'b1;
    end else begin
      whole = add_whole - mag64;
    end
  end

  always_comb begin
    state_d     = state_q;
    tpc_d       = tpc_q;
    nom_d       = nom_q;
    wlo_d       = wlo_q;
    whi_d       = whi_q;
    start_d     = start_q;
    started_d   = started_q;
    last_d      = last_q;
    step_d      = step_q;
    phase_d     = phase_q;
    accum_d     = accum_q;
    sample_d    = sample_q;
    n_d         = n_q;
    ph_d        = ph_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    cand_d      = cand_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q;
    out_time_d  = out_time_q;
    out_kind_d  = out_kind_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICKS_PER_CORR: tpc_d   = cfg_data_i[CountBits-1:0];
        CFG_NOMINAL_STEP:   nom_d   = cfg_data_i[StepBits-1:0];
        CFG_WINDOW_LOW:     wlo_d   = cfg_data_i[StepBits-1:0];
        CFG_WINDOW_HIGH:    whi_d   = cfg_data_i[StepBits-1:0];
        CFG_START_TIME:     start_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_d = fine_sample_i & SampleMask;
          if (!started_q) begin
            last_d    = start_m;
            step_d    = nom_q;
            started_d = 1'b1;
          end
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        n_d  = n_eff;
        ph_d = ph_eff;
        neg_d = base < start_m;
        mag_d = (base < start_m) ? (start_m - base) : (base - start_m);
        if (ph_eff == '0) begin
          prod_d = '0;
          last_d = sample_q;
          quo_d  = DivBits'(elapsed[StepBits-1:0]) << FRACTION_BITS;
          rem_d  = '0;
          cnt_d  = '0;
          if (win_ok) begin
            kind_d  = KIND_ACCEPT;
            state_d = S_DIV;
          end else begin
            kind_d  = KIND_REJECT;
            state_d = S_CAND;
          end
        end else begin
          kind_d  = KIND_INTERP;
          state_d = S_MUL;
        end
      end
      S_DIV: begin
        rem_d = trial_ge ? CountBits'(trial - {1'b0, n_q}) : trial[CountBits-1:0];
        quo_d = {quo_q[DivBits-2:0], trial_ge};
        cnt_d = cnt_q + CntBits'(1);
        if (cnt_q == LastCnt) begin
          step_d  = (quo_d > StepMaxW) ? STEP_MAX : quo_d[StepBits-1:0];
          state_d = S_CAND;
        end
      end
      S_MUL: begin
        prod_d  = ProdBits'(step_q) * ProdBits'(ph_q);
        state_d = S_CAND;
      end
      S_CAND: begin
        if (cand_zero) begin
          cand_d = '0;
        end else if (whole > WholeMax) begin
          cand_d = '1;
        end else begin
          cand_d = (whole << FRACTION_BITS) | frac;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          accum_d     = acc_new;
          out_time_d  = TimeBits'(acc_new >> FRACTION_BITS);
          out_kind_d  = kind_q;
          out_valid_d = 1'b1;
          phase_d     = (ph_next >= {1'b0, n_q}) ? '0 : ph_next[CountBits-1:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tpc_q       <= RST_TICKS_PER_CORR;
      nom_q       <= RST_NOMINAL_STEP;
      wlo_q       <= RST_WINDOW_LOW;
      whi_q       <= RST_WINDOW_HIGH;
      start_q     <= '0;
      started_q   <= 1'b0;
      phase_q     <= '0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tpc_q       <= tpc_d;
      nom_q       <= nom_d;
      wlo_q       <= wlo_d;
      whi_q       <= whi_d;
      start_q     <= start_d;
      started_q   <= started_d;
      phase_q     <= phase_d;
      accum_q     <= accum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    step_q     <= step_d;
    sample_q   <= sample_d;
    n_q        <= n_d;
    ph_q       <= ph_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    prod_q     <= prod_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    cand_q     <= cand_d;
    kind_q     <= kind_d;
    out_time_q <= out_time_d;
    out_kind_q <= out_kind_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign current_time_o = out_time_q;
  assign tick_kind_o    = out_kind_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state is not one-hot");

  a_time_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> accum_q >= $past(accum_q)) else $error("kept time went backward");

  a_div_on_correction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (ph_q == '0) && (kind_q == KIND_ACCEPT))
    else $error("divider ran outside an accepted correction");

  a_mul_on_interp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (ph_q != '0) && (kind_q == KIND_INTERP))
    else $error("multiplier ran on a correction tick");

endmodule
`default_nettype wire

>>> dv/itb_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the time and kind of every tick item and compares them with the block.
module itb_checker import itb_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TimeBits-1:0]  fine_sample_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [TimeBits-1:0]  current_time_i,
  input  logic [1:0]           tick_kind_i,
  input  logic                 cfg_we_i,
  input  logic [IdxBits-1:0]   cfg_idx_i,
  input  logic [TimeBits-1:0]  cfg_data_i,
  output int                   fails_o,
  output int                   pending_o,
  output int                   interp_seen_o,
  output int                   accept_seen_o,
  output int                   reject_seen_o
);

  localparam logic [63:0] FracMask = (64'd1 << FRACTION_BITS) - 64'd1;
  localparam logic [63:0] WholeMax = {64{1'b1}} >> FRACTION_BITS;

  logic [CountBits-1:0] corr_ticks;
  logic [StepBits-1:0]  nom_step;
  logic [StepBits-1:0]  win_lo;
  logic [StepBits-1:0]  win_hi;
  logic [TimeBits-1:0]  zero_point;

  logic [TimeBits-1:0]  ref_sample;
  logic [StepBits-1:0]  tick_step;
  logic [CountBits-1:0] phase;
  logic [AccBits-1:0]   kept_time;
  bit                   running;

  logic [TimeBits-1:0]  expected_times[$];
  kind_e                expected_kinds[$];
  logic [TimeBits-1:0]  want_time;
  kind_e                want_kind;

  // Signed whole offset plus a fixed-point addend; negative gives zero, overflow saturates.
  function automatic logic [63:0] to_fixed_time(input bit below, input logic [63:0] mag,
                                                input logic [63:0] add);
    logic [64:0] whole;
    logic [63:0] add_whole;
    add_whole = add >> FRACTION_BITS;
    if (!below) begin
      whole = {1'b0, mag} + {1'b0, add_whole};
    end else begin
      if (add_whole < mag) return '0;
      whole = {1'b0, add_whole - mag};
    end
    if (whole > {1'b0, WholeMax}) return '1;
    return (whole[63:0] << FRACTION_BITS) | (add & FracMask);
  endfunction

  task automatic predict_tick(input logic [TimeBits-1:0] sample);
    logic [63:0] n_eff;
    logic [63:0] ph;
    logic [63:0] elapsed;
    logic [63:0] quot;
    logic [63:0] add;
    logic [63:0] cand;
    logic [63:0] whole_time;
    kind_e       kind;
    n_eff = (corr_ticks == '0) ? 64'd1 : 64'(corr_ticks);
    if (!running) begin
      ref_sample = zero_point;
      tick_step = nom_step;
      running = 1'b1;
    end
    ph = 64'(phase);
    if (ph >= n_eff) ph = '0;
    if (ph == '0) begin
      kind = KIND_REJECT;
      if (sample >= ref_sample) begin
        elapsed = 64'(sample) - 64'(ref_sample);
        if (elapsed >= 64'(win_lo) && elapsed <= 64'(win_hi)) begin
          quot = (elapsed << FRACTION_BITS) / n_eff;
          tick_step = (quot > 64'(STEP_MAX)) ? STEP_MAX : quot[StepBits-1:0];
          kind = KIND_ACCEPT;
        end
      end
      ref_sample = sample;
      add = '0;
    end else begin
      kind = KIND_INTERP;
      add = 64'(tick_step) * ph;
    end
    if (ref_sample >= zero_point) begin
      cand = to_fixed_time(1'b0, 64'(ref_sample - zero_point), add);
    end else begin
      cand = to_fixed_time(1'b1, 64'(zero_point - ref_sample), add);
    end
    if (cand > kept_time) kept_time = cand;
    ph = ph + 64'd1;
    if (ph >= n_eff) ph = '0;
    phase = ph[CountBits-1:0];
    whole_time = kept_time >> FRACTION_BITS;
    expected_times.push_back(whole_time[TimeBits-1:0]);
    expected_kinds.push_back(kind);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_ticks = RST_TICKS_PER_CORR;
      nom_step = RST_NOMINAL_STEP;
      win_lo = RST_WINDOW_LOW;
      win_hi = RST_WINDOW_HIGH;
      zero_point = '0;
      ref_sample = '0;
      tick_step = RST_NOMINAL_STEP;
      phase = '0;
      kept_time = '0;
      running = 1'b0;
      expected_times.delete();
      expected_kinds.delete();
      fails_o = 0;
      pending_o = 0;
      interp_seen_o = 0;
      accept_seen_o = 0;
      reject_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TICKS_PER_CORR: corr_ticks = cfg_data_i[CountBits-1:0];
          CFG_NOMINAL_STEP:   nom_step = cfg_data_i[StepBits-1:0];
          CFG_WINDOW_LOW:     win_lo = cfg_data_i[StepBits-1:0];
          CFG_WINDOW_HIGH:    win_hi = cfg_data_i[StepBits-1:0];
          CFG_START_TIME:     zero_point = cfg_data_i;
          default: ;
        endcase
        // Before the first tick the reference point and step follow the registers.
        if (!running) begin
          ref_sample = zero_point;
          tick_step = nom_step;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_times.size() == 0) begin
          $error("result with no tick item waiting: current_time %0d, tick_kind %0d",
                 current_time_i, tick_kind_i);
          fails_o++;
        end else begin
          want_time = expected_times.pop_front();
          want_kind = expected_kinds.pop_front();
          if (current_time_i !== want_time) begin
            $error("current_time: expected %0d, got %0d", want_time, current_time_i);
            fails_o++;
          end
          if (tick_kind_i !== want_kind) begin
            $error("tick_kind: expected %0d, got %0d", want_kind, tick_kind_i);
            fails_o++;
          end
          case (want_kind)
            KIND_INTERP: interp_seen_o++;
            KIND_ACCEPT: accept_seen_o++;
            default:     reject_seen_o++;
          endcase
        end
      end
      if (in_valid_i && in_ready_i) predict_tick(fine_sample_i);
      pending_o = expected_times.size();
    end
  end

endmodule

>>> dv/tb_interpolated_timebase.sv
`timescale 1ns / 1ps
// Testbench top for the interpolated timebase: clock, reset, stimulus, watchdog and verdict.
module tb_interpolated_timebase;
  import itb_pkg::*;

  localparam int FracBits   = 16;
  localparam int LongHold   = 300;
  localparam int StallLimit = 3000;
  localparam int TailCycles = 64;
  localparam int ItemTarget = 400;

  localparam logic [IdxBits-1:0]  CFG_SPARE_IDX = 3'd7;
  localparam logic [TimeBits-1:0] SampleMax     = '1;
  localparam logic [StepBits-1:0] RegMax        = '1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [TimeBits-1:0]  fine_sample;
  logic                 out_valid;
  logic                 out_ready;
  logic [TimeBits-1:0]  current_time;
  logic [1:0]           tick_kind;
  logic                 cfg_we;
  logic [IdxBits-1:0]   cfg_idx;
  logic [TimeBits-1:0]  cfg_data;

  int fails;
  int pending;
  int interp_seen;
  int accept_seen;
  int reject_seen;
  int items_sent;
  int settings_used;
  int idle_cycles;
  int phase_no;
  bit quiet;
  bit hold_request;
  logic [63:0] fine_clock;

  interpolated_timebase u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .fine_sample_i  (fine_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .current_time_o (current_time),
    .tick_kind_o    (tick_kind),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  itb_checker #(.FRACTION_BITS(FracBits)) u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .fine_sample_i  (fine_sample),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .current_time_i (current_time),
    .tick_kind_i    (tick_kind),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fails_o        (fails),
    .pending_o      (pending),
    .interp_seen_o  (interp_seen),
    .accept_seen_o  (accept_seen),
    .reject_seen_o  (reject_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("FAIL interpolated_timebase");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [TimeBits-1:0] sample);
    in_valid <= 1'b1;
    fine_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IdxBits-1:0] idx, input logic [TimeBits-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CountBits-1:0] n, input logic [StepBits-1:0] nom,
                           input logic [StepBits-1:0] lo, input logic [StepBits-1:0] hi,
                           input logic [TimeBits-1:0] st);
    drain();
    write_reg(CFG_TICKS_PER_CORR, TimeBits'(n));
    write_reg(CFG_NOMINAL_STEP, TimeBits'(nom));
    write_reg(CFG_WINDOW_LOW, TimeBits'(lo));
    write_reg(CFG_WINDOW_HIGH, TimeBits'(hi));
    write_reg(CFG_START_TIME, st);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly steady ticks of one period with jitter, plus backward samples and forward jumps.
  task automatic random_phase(input int count, input bit stall_sink);
    logic [CountBits-1:0] n;
    logic [63:0]          n_eff;
    logic [63:0]          span;
    logic [63:0]          slack;
    logic [63:0]          lo;
    logic [63:0]          hi;
    logic [63:0]          st;
    logic [63:0]          sample;
    int unsigned          period;
    int unsigned          jitter;
    int                   pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) n = '0;
    else if (pick == 1) n = CountBits'(1);
    else if (pick < 16) n = CountBits'($urandom_range(2, 8));
    else n = CountBits'($urandom_range(9, 40));
    n_eff = (n == '0) ? 64'd1 : 64'(n);
    period = $urandom_range(50, 200000);
    jitter = $urandom_range(0, period / 20);
    span = n_eff * 64'(period);
    pick = $urandom_range(0, 9);
    if (pick < 6) slack = n_eff * 64'(jitter) + 64'($urandom_range(1, 100));
    else slack = 64'($urandom_range(0, jitter));
    lo = (span > slack) ? span - slack : 64'd0;
    hi = span + slack;
    if (pick == 9) begin
      lo = span * 2;
      hi = span / 2;
    end
    if ($urandom_range(0, 3) == 0) st = fine_clock + 64'($urandom_range(1, 50000));
    else st = 64'($urandom_range(0, 20000));
    configure(n, StepBits'({$urandom, $urandom}), StepBits'(lo), StepBits'(hi),
              TimeBits'(st));
    if (stall_sink) hold_request = 1'b1;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        sample = fine_clock - 64'($urandom_range(1, 5000));
      end else begin
        if (pick == 1) fine_clock += 64'($urandom_range(1, 1000000));
        else fine_clock += 64'(period - jitter + $urandom_range(0, 2 * jitter));
        sample = fine_clock;
      end
      offer(sample[TimeBits-1:0]);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    fine_sample = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TICKS_PER_CORR;
    cfg_data = '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    fine_clock = 64'd10000;
    items_sent = 0;
    settings_used = 0;
    phase_no = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First tick latches start and step; then a negative elapsed time and negative candidates.
    configure(CountBits'(4), StepBits'(100) << FracBits, StepBits'(300), StepBits'(500),
              TimeBits'(1000));
    offer(1400);
    offer(0);
    offer(SampleMax);
    offer(0);
    offer(1300);
    repeat (3) offer(0);
    offer(500);
    repeat (3) offer(0);
    offer(0);

    // Raise N, then lower it below the running phase; the window is empty.
    configure(CountBits'(1000), StepBits'(50) << FracBits, StepBits'(1000), StepBits'(10),
              '0);
    offer(48'hAAAA_AAAA_AAAA);
    offer(48'h5555_5555_5555);
    offer(0);
    offer(0);
    configure(CountBits'(3), '0, StepBits'(1000), StepBits'(10), '0);
    offer(5000);
    offer(0);
    offer(0);

    // N of zero and one make every tick a correction.
    configure('0, StepBits'(100) << FracBits, '0, RegMax, '0);
    offer(6000);
    offer(5500);
    configure(CountBits'(1), StepBits'(100) << FracBits, '0, RegMax, '0);
    offer(7000);
    drain();
    write_reg(CFG_SPARE_IDX, SampleMax);
    cfg_we <= 1'b0;

    while (items_sent < ItemTarget - 60) begin
      if (phase_no == 2) begin
        configure(CountBits'(1023), '0, RegMax, '0, SampleMax);
        repeat (4) begin
          fine_clock += 64'd1000;
          offer(fine_clock[TimeBits-1:0]);
        end
      end
      random_phase($urandom_range(20, 40), phase_no == 4);
      phase_no++;
    end

    quiet = 1'b1;
    random_phase(30, 1'b0);
    random_phase(26, 1'b0);

    // Samples at the counter's top take the kept time to its largest whole value.
    configure(CountBits'(2), RegMax, '0, RegMax, '0);
    repeat (4) offer(SampleMax);

    drain();
    repeat (TailCycles) @(negedge clk);
    $display("Sent %0d tick items over %0d register settings, with sink stalls and source gaps.",
             items_sent, settings_used);
    $display("Checked %0d interpolated ticks, %0d accepted and %0d rejected corrections.",
             interp_seen, accept_seen, reject_seen);
    if (fails == 0 && pending == 0) begin
      $display("PASS interpolated_timebase");
    end else begin
      $display("FAIL interpolated_timebase");
    end
    $finish;
  end

endmodule
